// ----- hdl/urm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants of the ultrasonic range measurement core.
// ----------------------------------------------------------------------------
package urm_pkg;

    // Default width of the echo wait and pulse width counters
    localparam int URM_COUNTER_WIDTH = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TIMEOUT_US      = 2'd0,
        CFG_TRIGGER_HIGH_US = 2'd1,
        CFG_TRIGGER_LOW_US  = 2'd2,
        CFG_SCALE_Q16       = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [15:0] TIMEOUT_US_RST      = 16'd30000;
    localparam logic [7:0]  TRIGGER_HIGH_US_RST = 8'd10;
    localparam logic [7:0]  TRIGGER_LOW_US_RST  = 8'd2;
    localparam logic [15:0] SCALE_Q16_RST       = 16'd1124;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LOW  = 2'd1,
        PH_HIGH = 2'd2,
        PH_WAIT = 2'd3
    } phase_t;

    // Result fields leaving the control stage
    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [15:0] pulse_width_us;
    } urm_stage_t;

endpackage : urm_pkg
`default_nettype wire

// ----- hdl/urm_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_if
// Handshake channels of the ultrasonic range measurement core: tick input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface urm_req_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface : urm_req_if

interface urm_res_if;
    logic        valid;
    logic        ready;
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        timed_out;
    logic [15:0] pulse_width_us;
    logic [17:0] distance_q8;

    modport source (output valid, output trigger_level, output busy_res,
                    output done_res, output timed_out, output pulse_width_us,
                    output distance_q8, input ready);
    modport sink   (input valid, input trigger_level, input busy_res,
                    input done_res, input timed_out, input pulse_width_us,
                    input distance_q8, output ready);
endinterface : urm_res_if

interface urm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : urm_cfg_if
`default_nettype wire

// ----- hdl/urm_range_scale.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urm_range_scale
// Output stage: scales the pulse width to Q8 centimetres, saturates and
// holds the result request until the consumer takes it.
// ----------------------------------------------------------------------------
module urm_range_scale
    import urm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        stage_valid,
    input  wire urm_stage_t  stage_data,
    input  wire logic [15:0] scale_q16,
    output logic             stage_take,
    urm_res_if.source        res
);

    logic        valid_reg;
    logic        valid_next;
    urm_stage_t  data_reg;
    logic [17:0] dist_reg;
    logic [31:0] product;
    logic [23:0] dist_full;
    logic [17:0] dist_next;

    // Take a new request when the output register is empty or draining
    assign stage_take = stage_valid && (!valid_reg || res.ready);

    // Multiply, drop eight fraction bits, saturate to 18 bits
    always_comb
    begin
        product   = 32'(stage_data.pulse_width_us) * 32'(scale_q16);
        dist_full = product[31:8];
        dist_next = (|dist_full[23:18]) ? 18'h3FFFF : dist_full[17:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_take)
            valid_next = 1'b1;
        else if (res.ready)
            valid_next = 1'b0;
    end

    // Hold valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Load payload
    always_ff @(posedge clk)
    begin
        if (stage_take)
        begin
            data_reg <= stage_data;
            dist_reg <= dist_next;
        end
    end

    assign res.valid          = valid_reg;
    assign res.trigger_level  = data_reg.trigger_level;
    assign res.busy_res       = data_reg.busy_res;
    assign res.done_res       = data_reg.done_res;
    assign res.timed_out      = data_reg.timed_out;
    assign res.pulse_width_us = data_reg.pulse_width_us;
    assign res.distance_q8    = dist_reg;

endmodule : urm_range_scale
`default_nettype wire

// ----- hdl/ultrasonic_range_measure_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_range_measure_core
// Ultrasonic ranger controller: one request per microsecond tick drives the
// trigger sequence, times the echo pulse and reports width and distance.
// ----------------------------------------------------------------------------
// Path: a tick's result passes the control stage register, then the scaling
//   multiplier's output register, and is offered from there.
// Throughput: one tick per cycle unless the result channel stalls; the control
//   state updates in the accept cycle, so consecutive ticks follow without a gap.
// Reset: rst_n clears the phase, counters and valid flags at once and loads
//   the configuration registers with their default values.
// ----------------------------------------------------------------------------
module ultrasonic_range_measure_core
    import urm_pkg::*;
#(
    parameter int COUNTER_WIDTH = URM_COUNTER_WIDTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    urm_req_if.sink   req,
    urm_cfg_if.sink   cfg,
    urm_res_if.source res
);

    localparam int CMPW = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
    localparam logic [COUNTER_WIDTH-1:0] CMAX = {COUNTER_WIDTH{1'b1}};

    // Configuration registers
    logic [15:0] timeout_reg;
    logic [7:0]  trig_high_reg;
    logic [7:0]  trig_low_reg;
    logic [15:0] scale_reg;

    // Control state
    phase_t                   phase_reg,   phase_next;
    logic [7:0]               pcount_reg,  pcount_next;
    logic [COUNTER_WIDTH-1:0] wait_reg,    wait_next;
    logic [COUNTER_WIDTH-1:0] width_reg,   width_next;
    logic                     seen_reg,    seen_next;
    logic                     last_echo_reg;

    // Stage register towards the scaling stage
    logic       stage_valid_reg, stage_valid_next;
    urm_stage_t stage_reg,       stage_next;
    logic       stage_take;
    logic       accept;

    logic            done;
    logic            tmo;
    logic [CMPW-1:0] width_ext;

    assign accept    = req.valid && req.ready;
    assign req.ready = !stage_valid_reg || stage_take;
    assign cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= TIMEOUT_US_RST;
            trig_high_reg <= TRIGGER_HIGH_US_RST;
            trig_low_reg  <= TRIGGER_LOW_US_RST;
            scale_reg     <= SCALE_Q16_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_TIMEOUT_US:      timeout_reg   <= cfg.data;
                CFG_TRIGGER_HIGH_US: trig_high_reg <= cfg.data[7:0];
                CFG_TRIGGER_LOW_US:  trig_low_reg  <= cfg.data[7:0];
                CFG_SCALE_Q16:       scale_reg     <= cfg.data;
                default:             ;
            endcase
        end
    end

    // Next phase, counters and per-tick result
    always_comb
    begin
        phase_next  = phase_reg;
        pcount_next = pcount_reg;
        wait_next   = wait_reg;
        width_next  = width_reg;
        seen_next   = seen_reg;
        done        = 1'b0;
        tmo         = 1'b0;
        width_ext   = '0;
        stage_next  = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (req.start_req)
                begin
                    phase_next  = (trig_low_reg != 8'd0) ? PH_LOW : PH_HIGH;
                    pcount_next = 8'd1;
                end
            end
            PH_LOW:
            begin
                if (pcount_reg >= trig_low_reg)
                begin
                    phase_next  = PH_HIGH;
                    pcount_next = 8'd1;
                end
                else
                    pcount_next = pcount_reg + 8'd1;
            end
            PH_HIGH:
            begin
                if (pcount_reg >= trig_high_reg)
                begin
                    phase_next  = PH_WAIT;
                    pcount_next = 8'd0;
                    wait_next   = '0;
                    width_next  = '0;
                    seen_next   = 1'b0;
                end
                else
                    pcount_next = pcount_reg + 8'd1;
            end
            PH_WAIT:
            begin
                // Advance the saturating counters
                if (wait_reg != CMAX)
                    wait_next = wait_reg + COUNTER_WIDTH'(1);
                if (seen_reg && (width_reg != CMAX))
                    width_next = width_reg + COUNTER_WIDTH'(1);
                // Rising edge restarts timing, falling edge after a rise ends it
                if (req.echo_level && !last_echo_reg)
                begin
                    seen_next  = 1'b1;
                    width_next = '0;
                end
                else if (!req.echo_level && last_echo_reg && seen_reg)
                    done = 1'b1;
                if (!done && (CMPW'(wait_next) >= CMPW'(timeout_reg)))
                begin
                    done = 1'b1;
                    tmo  = 1'b1;
                end
                if (done)
                begin
                    phase_next  = PH_IDLE;
                    pcount_next = 8'd0;
                    seen_next   = 1'b0;
                end
            end
            default: ;
        endcase

        // Saturate the reported width to 16 bits
        width_ext = CMPW'(width_next);
        stage_next.trigger_level = (phase_next == PH_HIGH);
        stage_next.busy_res      = (phase_next != PH_IDLE);
        stage_next.done_res      = done;
        stage_next.timed_out     = tmo;
        if (done && !tmo)
            stage_next.pulse_width_us = (width_ext > CMPW'(16'hFFFF)) ?
                                        16'hFFFF : width_ext[15:0];
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (stage_take)
            stage_valid_next = 1'b0;
    end

    // Hold control state; advance only on an accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            pcount_reg      <= 8'd0;
            wait_reg        <= '0;
            width_reg       <= '0;
            seen_reg        <= 1'b0;
            last_echo_reg   <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            if (accept)
            begin
                phase_reg     <= phase_next;
                pcount_reg    <= pcount_next;
                wait_reg      <= wait_next;
                width_reg     <= width_next;
                seen_reg      <= seen_next;
                last_echo_reg <= req.echo_level;
            end
        end
    end

    // Load stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
            stage_reg <= stage_next;
    end

    urm_range_scale u_range_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid_reg),
        .stage_data  (stage_reg),
        .scale_q16   (scale_reg),
        .stage_take  (stage_take),
        .res         (res)
    );

endmodule : ultrasonic_range_measure_core
`default_nettype wire

// ----- tb/tb_ultrasonic_range_measure_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_measure_core
// Self-checking bench for the ultrasonic ranger core. Each accepted tick
// request advances a local cycle-accurate ranger predictor; every result
// leaving the core is compared field by field with the oldest prediction.
// Directed cases cover the trigger sequencing corners, edge handling and
// timeout races, then random measurements with random settings follow under
// varying sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_measure_core;
    import urm_pkg::*;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct packed {
        logic        trig;
        logic        busy;
        logic        done;
        logic        tmo;
        logic [15:0] width;
        logic [17:0] dist_q8;
    } range_report_t;

    logic clk = 1'b0;
    logic rst_n;

    urm_req_if req_ch ();
    urm_cfg_if cfg_ch ();
    urm_res_if res_ch ();

    ultrasonic_range_measure_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .cfg   (cfg_ch),
        .res   (res_ch)
    );

    // Shadow copy of the configuration registers
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_trig_high;
    logic [7:0]  cfg_trig_low;
    logic [15:0] cfg_scale;

    // Predicted ranger state
    phase_t      rg_phase;
    logic [7:0]  rg_count;
    logic [15:0] rg_wait;
    logic [15:0] rg_width;
    logic        rg_seen;
    logic        rg_last;

    range_report_t range_reports_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches   = 0;
    int ticks_sent   = 0;
    int results_seen = 0;
    int cycle_count  = 0;

    // Clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_ultrasonic_range_measure_core NOT OK");
            $finish;
        end
    end

    // Stall the result channel at random
    always @(posedge clk)
    begin
        res_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %0d expected %0d", results_seen, field, got, want);
        mismatches++;
    endtask

    // Compare each delivered result with the oldest prediction
    always @(posedge clk)
    begin : check_results
        range_report_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (range_reports_q.size() == 0)
                report_mismatch("unexpected result", 32'd0, 32'd0);
            else
            begin
                want = range_reports_q.pop_front();
                if (res_ch.trigger_level !== want.trig)
                    report_mismatch("trigger_level", 32'(res_ch.trigger_level),
                                    32'(want.trig));
                if (res_ch.busy_res !== want.busy)
                    report_mismatch("busy_res", 32'(res_ch.busy_res), 32'(want.busy));
                if (res_ch.done_res !== want.done)
                    report_mismatch("done_res", 32'(res_ch.done_res), 32'(want.done));
                if (res_ch.timed_out !== want.tmo)
                    report_mismatch("timed_out", 32'(res_ch.timed_out), 32'(want.tmo));
                if (res_ch.pulse_width_us !== want.width)
                    report_mismatch("pulse_width_us", 32'(res_ch.pulse_width_us),
                                    32'(want.width));
                if (res_ch.distance_q8 !== want.dist_q8)
                    report_mismatch("distance_q8", 32'(res_ch.distance_q8),
                                    32'(want.dist_q8));
            end
            results_seen++;
        end
    end

    // Advance the predicted ranger by one tick and queue its report
    task automatic advance_ranger(input logic start, input logic echo);
        range_report_t rpt;
        logic [31:0]   prod;
        rpt = '0;
        case (rg_phase)
            PH_IDLE:
            begin
                if (start)
                begin
                    rg_phase = (cfg_trig_low != 8'd0) ? PH_LOW : PH_HIGH;
                    rg_count = 8'd1;
                end
            end
            PH_LOW:
            begin
                if (rg_count >= cfg_trig_low)
                begin
                    rg_phase = PH_HIGH;
                    rg_count = 8'd1;
                end
                else
                    rg_count = rg_count + 8'd1;
            end
            PH_HIGH:
            begin
                if (rg_count >= cfg_trig_high)
                begin
                    rg_phase = PH_WAIT;
                    rg_count = 8'd0;
                    rg_wait  = 16'd0;
                    rg_width = 16'd0;
                    rg_seen  = 1'b0;
                end
                else
                    rg_count = rg_count + 8'd1;
            end
            default:
            begin
                if (rg_wait != 16'hFFFF)
                    rg_wait = rg_wait + 16'd1;
                if (rg_seen && rg_width != 16'hFFFF)
                    rg_width = rg_width + 16'd1;
                // a rise restarts timing; a fall only counts after a rise
                if (echo && !rg_last)
                begin
                    rg_seen  = 1'b1;
                    rg_width = 16'd0;
                end
                else if (!echo && rg_last && rg_seen)
                    rpt.done = 1'b1;
                // a fall on the timeout tick still wins
                if (!rpt.done && rg_wait >= cfg_timeout)
                begin
                    rpt.done = 1'b1;
                    rpt.tmo  = 1'b1;
                end
                if (rpt.done)
                begin
                    if (!rpt.tmo)
                    begin
                        rpt.width = rg_width;
                        prod = ({16'd0, rg_width} * {16'd0, cfg_scale}) >> 8;
                        rpt.dist_q8 = (prod > 32'd262143) ? 18'h3FFFF : prod[17:0];
                    end
                    rg_phase = PH_IDLE;
                    rg_count = 8'd0;
                    rg_seen  = 1'b0;
                end
            end
        endcase
        rg_last  = echo;
        rpt.trig = (rg_phase == PH_HIGH);
        rpt.busy = (rg_phase != PH_IDLE);
        range_reports_q.push_back(rpt);
    endtask

    // Offer one tick request, idling first at random
    task automatic send_tick(input logic start, input logic echo);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid      <= 1'b1;
        req_ch.start_req  <= start;
        req_ch.echo_level <= echo;
        do
            @(posedge clk);
        while (!req_ch.ready);
        advance_ranger(start, echo);
        ticks_sent++;
    endtask

    // Drive the echo so that any running measurement ends quickly
    task automatic settle_ranger();
        while (rg_phase != PH_IDLE)
            send_tick(1'b0, rg_phase == PH_WAIT && !rg_seen && !rg_last);
    endtask

    // Drop the request and hold until every result has left the core
    task automatic drain_reports();
        req_ch.valid <= 1'b0;
        while (range_reports_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [15:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_TIMEOUT_US:      cfg_timeout   = value;
            CFG_TRIGGER_HIGH_US: cfg_trig_high = value[7:0];
            CFG_TRIGGER_LOW_US:  cfg_trig_low  = value[7:0];
            default:             cfg_scale     = value;
        endcase
    endtask

    // Finish the measurement, go quiet, then load all four registers
    task automatic program_ranger(input logic [15:0] timeout, input logic [7:0] high,
                                  input logic [7:0] low, input logic [15:0] scale);
        settle_ranger();
        drain_reports();
        write_register(CFG_TIMEOUT_US, timeout);
        write_register(CFG_TRIGGER_HIGH_US, {8'd0, high});
        write_register(CFG_TRIGGER_LOW_US, {8'd0, low});
        write_register(CFG_SCALE_Q16, scale);
    endtask

    // Start, run through the trigger, then echo low for lead ticks and high for width
    task automatic measure_pulse(input int lead, input int width, input bit noisy);
        int i;
        send_tick(1'b1, noisy ? 1'($urandom_range(1)) : 1'b0);
        while (rg_phase == PH_LOW || rg_phase == PH_HIGH)
            send_tick(noisy ? 1'($urandom_range(1)) : 1'b0,
                      noisy ? 1'($urandom_range(1)) : 1'b0);
        for (i = 0; i < lead && rg_phase == PH_WAIT; i++)
            send_tick(noisy ? 1'($urandom_range(1)) : 1'b0, 1'b0);
        for (i = 0; i < width && rg_phase == PH_WAIT; i++)
            send_tick(noisy ? 1'($urandom_range(1)) : 1'b0, 1'b1);
        if (rg_phase == PH_WAIT)
            send_tick(noisy ? 1'($urandom_range(1)) : 1'b0, 1'b0);
    endtask

    task automatic test_reset_defaults();
        measure_pulse(3, 20, 1'b0);
    endtask

    task automatic test_edge_cases();
        // no low phase, high time of zero, echo high before the wait phase
        program_ranger(16'd6, 8'd0, 8'd0, 16'hFFFF);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);      // start while busy
        send_tick(1'b0, 1'b0);      // fall without a rise
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);      // end of pulse, start on the same tick
        send_tick(1'b0, 1'b0);
        // fall on the timeout tick, then a plain timeout
        program_ranger(16'd3, 8'd1, 8'd1, 16'd0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        // timeout of zero
        program_ranger(16'd0, 8'd0, 8'd0, SCALE_Q16_RST);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
    endtask

    // Pulse whose distance saturates at the largest scale
    task automatic test_distance_saturation();
        program_ranger(16'd2000, 8'd2, 8'd1, 16'hFFFF);
        measure_pulse(0, 1026, 1'b0);
    endtask

    task automatic test_random_mix(input int n_ticks);
        int          first;
        int          lead;
        int          width;
        bit          noisy;
        logic [15:0] timeout;
        logic [15:0] scale;
        logic [7:0]  high;
        logic [7:0]  low;
        first = ticks_sent;
        while (ticks_sent - first < n_ticks)
        begin
            // new settings now and then, extremes included
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(7))
                    0:       timeout = 16'd0;
                    1:       timeout = 16'd1;
                    2:       timeout = 16'hFFFF;
                    default: timeout = 16'($urandom_range(2, 60));
                endcase
                case ($urandom_range(9))
                    0:       high = 8'd0;
                    1:       high = 8'hFF;
                    default: high = 8'($urandom_range(1, 5));
                endcase
                case ($urandom_range(9))
                    0:       low = 8'hFF;
                    1, 2, 3: low = 8'd0;
                    default: low = 8'($urandom_range(1, 5));
                endcase
                case ($urandom_range(5))
                    0:       scale = 16'd0;
                    1:       scale = 16'hFFFF;
                    default: scale = 16'($urandom_range(0, 65535));
                endcase
                program_ranger(timeout, high, low, scale);
            end
            if ($urandom_range(4) == 0)
            begin
                // noise: random starts and echo levels
                repeat ($urandom_range(1, 12))
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            else
            begin
                settle_ranger();
                lead  = $urandom_range(0, 6);
                width = ($urandom_range(3) == 0) ? $urandom_range(0, 70)
                                                 : $urandom_range(0, 12);
                noisy = ($urandom_range(3) == 0);
                measure_pulse(lead, width, noisy);
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.start_req  = 1'b0;
        req_ch.echo_level = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_TIMEOUT_US;
        cfg_ch.data       = 16'd0;
        res_ch.ready      = 1'b0;
        cfg_timeout       = TIMEOUT_US_RST;
        cfg_trig_high     = TRIGGER_HIGH_US_RST;
        cfg_trig_low      = TRIGGER_LOW_US_RST;
        cfg_scale         = SCALE_Q16_RST;
        rg_phase          = PH_IDLE;
        rg_count          = 8'd0;
        rg_wait           = 16'd0;
        rg_width          = 16'd0;
        rg_seen           = 1'b0;
        rg_last           = 1'b0;
        send_idle_pct     = 33;
        recv_idle_pct     = 70;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_edge_cases();
        test_random_mix(80);

        send_idle_pct = 70;
        recv_idle_pct = 33;
        test_distance_saturation();
        test_random_mix(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(80);

        drain_reports();
        if (mismatches == 0)
            $display("tb_ultrasonic_range_measure_core OK");
        else
            $display("tb_ultrasonic_range_measure_core NOT OK");
        $finish;
    end

endmodule : tb_ultrasonic_range_measure_core

// ----- files.f -----
hdl/urm_pkg.sv
hdl/urm_if.sv
hdl/urm_range_scale.sv
hdl/ultrasonic_range_measure_core.sv
tb/tb_ultrasonic_range_measure_core.sv
